@@ src/prsp_pkg.sv @@
// ----------------------------------------------------------------------------
// prsp_pkg
// types and constants shared by the port range spec parser modules
// ----------------------------------------------------------------------------
package prsp_pkg;

	localparam int unsigned PORT_W = 16;
	localparam int unsigned ACC_W  = 17;
	localparam int unsigned CH_W   = 8;
	localparam int unsigned ERR_W  = 3;

	localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

	localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CH_W-1:0] CH_DASH  = 8'h2d;
	localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_ERR
	} phase_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE      = 3'd0,
		ERR_EMPTY     = 3'd1,
		ERR_NOT_COMMA = 3'd2,
		ERR_ORDER     = 3'd3,
		ERR_MISSING   = 3'd4,
		ERR_INVALID   = 3'd5
	} err_t;

	typedef struct packed {
		phase_t             phase;
		logic [PORT_W-1:0]  start_value;
		logic [ACC_W-1:0]   accum;
	} state_t;

	typedef struct packed {
		logic               range_valid;
		logic [PORT_W-1:0]  start_port;
		logic [PORT_W-1:0]  end_port;
		err_t               error_code;
		logic               done_res;
	} res_t;

endpackage

@@ src/prsp_step.sv @@
// ----------------------------------------------------------------------------
// prsp_step
// next state and result for one character of the port list
// ----------------------------------------------------------------------------
module prsp_step (
	input  logic [prsp_pkg::CH_W-1:0] ch,
	input  logic                      last,
	input  prsp_pkg::state_t          cur,
	output prsp_pkg::state_t          nxt,
	output logic                      has_res,
	output prsp_pkg::res_t            res
);

	localparam prsp_pkg::state_t CLEAR = '{
		phase:       prsp_pkg::PH_FIRST,
		start_value: '0,
		accum:       '0
	};

	logic                           digit;
	logic [3:0]                     dval;
	logic [prsp_pkg::ACC_W+3:0]     mac;
	logic [prsp_pkg::ACC_W-1:0]     acc_sat;
	logic                           sat_ok;
	logic                           acc_ok;
	logic                           below;
	logic [prsp_pkg::PORT_W-1:0]    sep_s;
	logic [prsp_pkg::PORT_W-1:0]    sep_e;
	logic                           sep;
	prsp_pkg::err_t                 sep_err;

	assign digit = (ch >= prsp_pkg::CH_ZERO) && (ch <= prsp_pkg::CH_NINE);
	assign dval  = 4'(ch - prsp_pkg::CH_ZERO);

	// accum * 10 + digit, then saturate
	assign mac = {1'b0, cur.accum, 3'b000} + {3'b000, cur.accum, 1'b0}
		+ {{(prsp_pkg::ACC_W){1'b0}}, dval};
	assign acc_sat = (mac > {4'b0000, prsp_pkg::ACC_SAT}) ? prsp_pkg::ACC_SAT
		: mac[prsp_pkg::ACC_W-1:0];

	assign sat_ok = (acc_sat != '0) && !acc_sat[prsp_pkg::ACC_W-1];
	assign acc_ok = (cur.accum != '0) && !cur.accum[prsp_pkg::ACC_W-1];
	assign below  = cur.accum < {1'b0, cur.start_value};

	always_comb begin
		nxt     = cur;
		has_res = 1'b0;
		res     = '0;
		sep     = 1'b0;
		sep_s   = '0;
		sep_e   = '0;
		sep_err = prsp_pkg::ERR_NONE;

		if (cur.phase == prsp_pkg::PH_ERR) begin
			if (last) begin
				nxt          = CLEAR;
				has_res      = 1'b1;
				res.done_res = 1'b1;
			end
		end else if (digit) begin
			nxt.accum = acc_sat;
			if (last) begin
				has_res      = 1'b1;
				res.done_res = 1'b1;
				if (!sat_ok) begin
					res.error_code = prsp_pkg::ERR_INVALID;
				end else if (cur.phase == prsp_pkg::PH_SECOND) begin
					if (acc_sat < {1'b0, cur.start_value}) begin
						res.error_code = prsp_pkg::ERR_ORDER;
					end else begin
						res.range_valid = 1'b1;
						res.start_port  = cur.start_value;
						res.end_port    = acc_sat[prsp_pkg::PORT_W-1:0];
					end
				end else begin
					res.range_valid = 1'b1;
					res.start_port  = acc_sat[prsp_pkg::PORT_W-1:0];
					res.end_port    = acc_sat[prsp_pkg::PORT_W-1:0];
				end
				nxt = CLEAR;
			end
		end else if (!acc_ok) begin
			has_res        = 1'b1;
			res.error_code = prsp_pkg::ERR_INVALID;
			res.done_res   = last;
			if (last) begin
				nxt = CLEAR;
			end else begin
				nxt.phase = prsp_pkg::PH_ERR;
			end
		end else if (cur.phase == prsp_pkg::PH_SECOND) begin
			if (below) begin
				has_res        = 1'b1;
				res.error_code = prsp_pkg::ERR_ORDER;
				res.done_res   = last;
				if (last) begin
					nxt = CLEAR;
				end else begin
					nxt.phase = prsp_pkg::PH_ERR;
				end
			end else begin
				sep   = 1'b1;
				sep_s = cur.start_value;
				sep_e = cur.accum[prsp_pkg::PORT_W-1:0];
			end
		end else if (ch == prsp_pkg::CH_DASH) begin
			if (last) begin
				nxt            = CLEAR;
				has_res        = 1'b1;
				res.error_code = prsp_pkg::ERR_MISSING;
				res.done_res   = 1'b1;
			end else begin
				nxt.start_value = cur.accum[prsp_pkg::PORT_W-1:0];
				nxt.accum       = '0;
				nxt.phase       = prsp_pkg::PH_SECOND;
			end
		end else begin
			sep   = 1'b1;
			sep_s = cur.accum[prsp_pkg::PORT_W-1:0];
			sep_e = cur.accum[prsp_pkg::PORT_W-1:0];
		end

		// element complete, this character is its separator
		if (sep) begin
			if (ch != prsp_pkg::CH_COMMA) begin
				sep_err = prsp_pkg::ERR_NOT_COMMA;
			end else if (last) begin
				sep_err = prsp_pkg::ERR_EMPTY;
			end
			has_res         = 1'b1;
			res.range_valid = 1'b1;
			res.start_port  = sep_s;
			res.end_port    = sep_e;
			res.error_code  = sep_err;
			res.done_res    = last;
			if (last) begin
				nxt = CLEAR;
			end else if (sep_err != prsp_pkg::ERR_NONE) begin
				nxt.phase = prsp_pkg::PH_ERR;
			end else begin
				nxt = CLEAR;
			end
		end
	end

endmodule

@@ src/port_range_spec_parser.sv @@
// ----------------------------------------------------------------------------
// port_range_spec_parser
// parses a port list such as 80,8000-8010 one character per item and
// reports each single port or range, errors and end of string
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   in      | in_valid in_ready ch last                        | to block
//   out     | out_valid out_ready range_valid start_port       | from block
//           | end_port error_code done_res                     |
//
// one character per cycle while no result waits on a stalled output; a result
// is presented once its item has passed the input register and the result register
// the parser state feeds back through the combinational step logic
// a stalled output holds one result while the input register still takes
// an item; characters that give no result keep flowing during a stall
// reset clears the parser state and the input and output valid flags
// ----------------------------------------------------------------------------
module port_range_spec_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [prsp_pkg::CH_W-1:0]       ch,
	input  logic                            last,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            range_valid,
	output logic [prsp_pkg::PORT_W-1:0]     start_port,
	output logic [prsp_pkg::PORT_W-1:0]     end_port,
	output logic [prsp_pkg::ERR_W-1:0]      error_code,
	output logic                            done_res
);

	logic                          valid_s1;
	logic [prsp_pkg::CH_W-1:0]     ch_s1;
	logic                          last_s1;
	prsp_pkg::state_t              state_q;
	prsp_pkg::state_t              state_nxt;
	logic                          has_res;
	prsp_pkg::res_t                res;
	prsp_pkg::res_t                res_q;
	logic                          out_valid_q;
	logic                          fire;

	prsp_step u_step (
		.ch      (ch_s1),
		.last    (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.has_res (has_res),
		.res     (res)
	);

	assign fire     = valid_s1 && (!has_res || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: prsp_pkg::PH_FIRST, start_value: '0, accum: '0};
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && has_res) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign range_valid = res_q.range_valid;
	assign start_port  = res_q.start_port;
	assign end_port    = res_q.end_port;
	assign error_code  = res_q.error_code;
	assign done_res    = res_q.done_res;

	// final character leaves the parser in its reset state
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last_s1 |=> state_q.phase == prsp_pkg::PH_FIRST
			&& state_q.accum == '0 && state_q.start_value == '0)
		else $error("state not cleared after final character");

	// accumulator saturates
	a_acc_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.accum <= prsp_pkg::ACC_SAT)
		else $error("accumulator above saturation");

	// a reported range is ordered and holds valid ports
	a_range_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_valid |-> start_port <= end_port && start_port != '0)
		else $error("bad range reported");

	// a result without range and without done carries an error
	a_err_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_valid && !done_res |-> error_code != prsp_pkg::ERR_NONE)
		else $error("empty result");

	// a pending result is not overwritten
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_q))
		else $error("pending result lost");

endmodule

@@ sim/tb_port_range_spec_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_port_range_spec_parser
// self-checking bench for the port list parser: characters go in one item at
// a time with random gaps, results come out under random stalls, and each
// result is compared field by field against a behavioral parser kept in step
// with the accepted characters
// ----------------------------------------------------------------------------
module tb_port_range_spec_parser;

	localparam int unsigned CYCLE_LIMIT = 400000;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_ready;
	logic [prsp_pkg::CH_W-1:0]     ch;
	logic                          last;
	logic                          out_valid;
	logic                          out_ready;
	logic                          range_valid;
	logic [prsp_pkg::PORT_W-1:0]   start_port;
	logic [prsp_pkg::PORT_W-1:0]   end_port;
	logic [prsp_pkg::ERR_W-1:0]    error_code;
	logic                          done_res;

	// parser state mirrored from the accepted characters
	prsp_pkg::phase_t              ps_phase;
	logic [prsp_pkg::PORT_W-1:0]   ps_first;
	logic [prsp_pkg::ACC_W-1:0]    ps_acc;

	prsp_pkg::res_t                exp_results[$];
	logic [prsp_pkg::CH_W-1:0]     spec_buf[$];
	int unsigned                   n_mismatch;
	int unsigned                   n_sent;
	int unsigned                   n_cycles;
	int                            stall_left;
	bit                            idle_on;

	port_range_spec_parser uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.ch         (ch),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.range_valid(range_valid),
		.start_port (start_port),
		.end_port   (end_port),
		.error_code (error_code),
		.done_res   (done_res)
	);

	always #6 clk = ~clk;

	function automatic void clear_parse();
		ps_phase = prsp_pkg::PH_FIRST;
		ps_first = '0;
		ps_acc   = '0;
	endfunction

	function automatic bit port_ok(input logic [prsp_pkg::ACC_W-1:0] v);
		return v != '0 && !v[prsp_pkg::ACC_W-1];
	endfunction

	// one character of the spec; returns 1 when it yields a result
	function automatic bit parse_step(input logic [prsp_pkg::CH_W-1:0] c, input logic l,
			output prsp_pkg::res_t r);
		int unsigned v;
		bit          is_dig;
		is_dig = (c >= prsp_pkg::CH_ZERO) && (c <= prsp_pkg::CH_NINE);
		r = '0;
		r.error_code = prsp_pkg::ERR_NONE;
		if (ps_phase == prsp_pkg::PH_ERR) begin
			if (!l)
				return 0;
			clear_parse();
			r.done_res = 1'b1;
			return 1;
		end
		if (is_dig) begin
			v = ps_acc * 10 + (c - prsp_pkg::CH_ZERO);
			ps_acc = (v > prsp_pkg::ACC_SAT) ? prsp_pkg::ACC_SAT : v[prsp_pkg::ACC_W-1:0];
			if (!l)
				return 0;
			r.done_res = 1'b1;
			if (!port_ok(ps_acc)) begin
				r.error_code = prsp_pkg::ERR_INVALID;
			end else if (ps_phase == prsp_pkg::PH_SECOND) begin
				if (ps_acc < ps_first) begin
					r.error_code = prsp_pkg::ERR_ORDER;
				end else begin
					r.range_valid = 1'b1;
					r.start_port  = ps_first;
					r.end_port    = ps_acc[prsp_pkg::PORT_W-1:0];
				end
			end else begin
				r.range_valid = 1'b1;
				r.start_port  = ps_acc[prsp_pkg::PORT_W-1:0];
				r.end_port    = ps_acc[prsp_pkg::PORT_W-1:0];
			end
			clear_parse();
			return 1;
		end
		// non-digit closes the current port
		r.done_res = l;
		if (!port_ok(ps_acc) || (ps_phase == prsp_pkg::PH_SECOND && ps_acc < ps_first)) begin
			r.error_code = port_ok(ps_acc) ? prsp_pkg::ERR_ORDER : prsp_pkg::ERR_INVALID;
			if (l)
				clear_parse();
			else
				ps_phase = prsp_pkg::PH_ERR;
			return 1;
		end
		if (ps_phase == prsp_pkg::PH_SECOND) begin
			r.start_port = ps_first;
		end else if (c == prsp_pkg::CH_DASH) begin
			if (l) begin
				clear_parse();
				r.error_code = prsp_pkg::ERR_MISSING;
				return 1;
			end
			ps_first = ps_acc[prsp_pkg::PORT_W-1:0];
			ps_acc   = '0;
			ps_phase = prsp_pkg::PH_SECOND;
			return 0;
		end else begin
			r.start_port = ps_acc[prsp_pkg::PORT_W-1:0];
		end
		r.range_valid = 1'b1;
		r.end_port    = ps_acc[prsp_pkg::PORT_W-1:0];
		if (c != prsp_pkg::CH_COMMA)
			r.error_code = prsp_pkg::ERR_NOT_COMMA;
		else if (l)
			r.error_code = prsp_pkg::ERR_EMPTY;
		if (!l && r.error_code != prsp_pkg::ERR_NONE)
			ps_phase = prsp_pkg::PH_ERR;
		else
			clear_parse();
		return 1;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		n_mismatch++;
	endtask

	task automatic send_char(input logic [prsp_pkg::CH_W-1:0] c, input logic l);
		prsp_pkg::res_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		last     <= l;
		do @(posedge clk); while (!in_ready);
		n_sent++;
		if (parse_step(c, l, r))
			exp_results.push_back(r);
	endtask

	task automatic send_buffer();
		foreach (spec_buf[i])
			send_char(spec_buf[i], i == spec_buf.size() - 1);
		spec_buf.delete();
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			spec_buf.push_back(s[i]);
		send_buffer();
	endtask

	function automatic void append_port(input int unsigned v);
		string s;
		if ($urandom_range(0, 9) == 0)
			spec_buf.push_back(prsp_pkg::CH_ZERO);
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			spec_buf.push_back(s[i]);
	endfunction

	function automatic int unsigned pick_port(input bit bad_ok);
		case ($urandom_range(0, bad_ok ? 11 : 8))
			0:       return 1;
			1:       return 65535;
			2:       return $urandom_range(1, 9);
			3:       return $urandom_range(10, 999);
			9:       return 0;
			10:      return 65536;
			11:      return $urandom_range(65537, 999999);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	// a list of ports and ranges; broken lists may carry bad ports and separators
	task automatic send_list(input bit broken);
		int unsigned n_el;
		int unsigned a;
		n_el = $urandom_range(1, 4);
		for (int k = 0; k < n_el; k++) begin
			a = pick_port(broken);
			append_port(a);
			if ($urandom_range(0, 2) == 0) begin
				spec_buf.push_back(prsp_pkg::CH_DASH);
				if (broken && $urandom_range(0, 3) == 0)
					append_port(pick_port(1'b1));
				else if (a <= 65535 && a > 0)
					append_port($urandom_range(a, 65535));
				else
					append_port(pick_port(1'b0));
			end
			if (k != n_el - 1) begin
				if (broken && $urandom_range(0, 4) == 0)
					spec_buf.push_back(8'($urandom_range(0, 255)));
				else
					spec_buf.push_back(prsp_pkg::CH_COMMA);
			end
		end
		if (broken && $urandom_range(0, 2) == 0)
			spec_buf.push_back($urandom_range(0, 1) ? prsp_pkg::CH_COMMA : prsp_pkg::CH_DASH);
		send_buffer();
	endtask

	task automatic test_single_and_range();
		send_str("1-65535,");
		send_str("65535");
	endtask

	task automatic test_error_codes();
		send_str("0");
		send_str("9-8");
		send_str("7-");
		send_str("5;");
		send_str("3-2,4");
	endtask

	task automatic test_ignore_after_error();
		send_str(",,");
		send_char(8'hff, 1'b0);
		send_char(8'h00, 1'b1);
	endtask

	task automatic test_random_lists(input int unsigned target);
		while (n_sent < target) begin
			idle_on = $urandom_range(0, 3) != 0;
			send_list($urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_random_noise(input int unsigned n_items);
		logic [prsp_pkg::CH_W-1:0] c;
		idle_on = 1'b1;
		repeat (n_items) begin
			case ($urandom_range(0, 3))
				0:       c = 8'($urandom_range(prsp_pkg::CH_ZERO, prsp_pkg::CH_NINE));
				1:       c = prsp_pkg::CH_COMMA;
				2:       c = prsp_pkg::CH_DASH;
				default: c = 8'($urandom_range(0, 255));
			endcase
			send_char(c, $urandom_range(0, 5) == 0);
		end
		send_char(prsp_pkg::CH_COMMA, 1'b1);
	endtask

	task automatic test_no_idle(input int unsigned target);
		idle_on = 1'b0;
		while (n_sent < target)
			send_list($urandom_range(0, 4) == 0);
	endtask

	// output side stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 16) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		prsp_pkg::res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (exp_results.size() == 0) begin
				report_mismatch("unexpected result, done_res", 32'(done_res), 0);
			end else begin
				e = exp_results.pop_front();
				if (range_valid !== e.range_valid)
					report_mismatch("range_valid", 32'(range_valid), 32'(e.range_valid));
				if (start_port !== e.start_port)
					report_mismatch("start_port", 32'(start_port), 32'(e.start_port));
				if (end_port !== e.end_port)
					report_mismatch("end_port", 32'(end_port), 32'(e.end_port));
				if (error_code !== e.error_code)
					report_mismatch("error_code", 32'(error_code), 32'(e.error_code));
				if (done_res !== e.done_res)
					report_mismatch("done_res", 32'(done_res), 32'(e.done_res));
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		ch         = '0;
		last       = 1'b0;
		out_ready  = 1'b0;
		n_mismatch = 0;
		n_sent     = 0;
		n_cycles   = 0;
		stall_left = 0;
		idle_on    = 1'b1;
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_and_range();
		test_error_codes();
		test_ignore_after_error();
		test_random_lists(1100);
		test_random_noise(150);
		test_no_idle(1450);

		in_valid <= 1'b0;
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (n_mismatch == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
